@@ sv/p2ba_pkg.sv @@
// ----------------------------------------------------------------------------
// p2ba_pkg
// Shared types, status codes and helpers for the power-of-two bin allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package p2ba_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STAT_BIN      = 2'd0;
	localparam logic [1:0] STAT_HEAP     = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;
	localparam logic [1:0] STAT_FREED    = 2'd3;

	typedef struct packed {
		logic        opcode;
		logic [31:0] address;
		logic [31:0] block_size;
	} req_t;

	typedef struct packed {
		logic [31:0] result_address;
		logic [1:0]  status;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic pop_done;
		logic free_step;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_free;
		logic pop_hit;
		logic rest_zero;
	} stat_t;

	// bit position of a one-hot word
	function automatic logic [4:0] onehot_index(input logic [31:0] v);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				r = r | 5'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/p2ba_dpath.sv @@
// ----------------------------------------------------------------------------
// p2ba_dpath
// Bin store, bin depth counters, heap top and limit, free splitter and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module p2ba_dpath #(
	parameter int BIN_DEPTH = 256,
	parameter int NUM_BINS  = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  p2ba_pkg::req_t       request,
	input  p2ba_pkg::cmd_t       cmd,
	input  wire                  limit_we,
	input  wire [31:0]           limit_data,
	output p2ba_pkg::stat_t      stat,
	output p2ba_pkg::rsp_t       response
);
	import p2ba_pkg::*;

	localparam int DEP_W  = $clog2(BIN_DEPTH);
	localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int MEM_N  = NUM_BINS * BIN_DEPTH;
	localparam int MEM_AW = $clog2(MEM_N);

	localparam logic [DEP_W-1:0] DEP_MAX = DEP_W'(BIN_DEPTH - 1);

	logic [31:0]      mem_q [MEM_N];
	logic [DEP_W-1:0] depth_q [NUM_BINS];
	logic [31:0]      heap_top_q;
	logic [31:0]      heap_limit_q;
	logic [31:0]      addr_q;
	logic [31:0]      rest_q;
	logic [31:0]      rd_q;
	logic [31:0]      res_q;
	logic [1:0]       status_q;

	// allocate side
	logic [4:0]       a_k;
	logic             a_pow2;
	logic             a_in_range;
	logic [BIN_W-1:0] a_bin;
	logic [32:0]      heap_sum;
	logic             heap_ok;

	// free side
	logic [31:0]      rest_nxt;
	logic [31:0]      piece;
	logic [4:0]       f_k;
	logic             f_in_range;
	logic [BIN_W-1:0] f_bin;
	logic [31:0]      piece_addr;

	// shared depth lookup
	logic [BIN_W-1:0] bin_sel;
	logic [DEP_W-1:0] dep_rd;
	logic [DEP_W-1:0] dep_push;
	logic [MEM_AW-1:0] rd_addr;
	logic [MEM_AW-1:0] wr_addr;

	always_comb begin
		a_pow2     = (request.block_size != 32'd0) &&
		             ((request.block_size & (request.block_size - 32'd1)) == 32'd0);
		a_k        = onehot_index(request.block_size);
		a_in_range = {1'b0, a_k} < 6'(NUM_BINS);
		a_bin      = a_k[BIN_W-1:0];

		rest_nxt   = rest_q & (rest_q - 32'd1);
		piece      = rest_q ^ rest_nxt;
		f_k        = onehot_index(piece);
		f_in_range = {1'b0, f_k} < 6'(NUM_BINS);
		f_bin      = f_k[BIN_W-1:0];
		piece_addr = addr_q + rest_nxt;

		bin_sel  = cmd.free_step ? f_bin : a_bin;
		dep_rd   = depth_q[bin_sel];
		dep_push = (dep_rd == DEP_MAX) ? dep_rd : dep_rd + DEP_W'(1);

		rd_addr = MEM_AW'(a_bin) * MEM_AW'(BIN_DEPTH) + MEM_AW'(dep_rd);
		wr_addr = MEM_AW'(f_bin) * MEM_AW'(BIN_DEPTH) + MEM_AW'(dep_push);

		heap_sum = {1'b0, heap_top_q} + {1'b0, request.block_size};
		heap_ok  = heap_sum < {1'b0, heap_limit_q};

		stat.is_free   = (request.opcode == OP_FREE);
		stat.pop_hit   = a_pow2 && a_in_range && (dep_rd != '0);
		stat.rest_zero = (rest_q == 32'd0);

		response.result_address = res_q;
		response.status         = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_top_q   <= '0;
			heap_limit_q <= '1;
			for (int i = 0; i < NUM_BINS; i++) begin
				depth_q[i] <= '0;
			end
		end else begin
			if (limit_we) begin
				heap_limit_q <= limit_data;
			end
			if (cmd.accept && !stat.is_free) begin
				if (stat.pop_hit) begin
					depth_q[bin_sel] <= dep_rd - DEP_W'(1);
				end else if (heap_ok) begin
					heap_top_q <= heap_sum[31:0];
				end
			end
			if (cmd.free_step && !stat.rest_zero && f_in_range) begin
				depth_q[bin_sel] <= dep_push;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= request.address;
			rest_q <= request.block_size;
			if (!stat.is_free && stat.pop_hit) begin
				rd_q <= mem_q[rd_addr];
			end
			if (!stat.is_free && !stat.pop_hit) begin
				res_q    <= heap_ok ? heap_top_q : '1;
				status_q <= heap_ok ? STAT_HEAP : STAT_OVERFLOW;
			end
		end
		if (cmd.pop_done) begin
			res_q    <= rd_q;
			status_q <= STAT_BIN;
		end
		if (cmd.free_step) begin
			if (stat.rest_zero) begin
				res_q    <= '0;
				status_q <= STAT_FREED;
			end else begin
				rest_q <= rest_nxt;
				if (f_in_range) begin
					mem_q[wr_addr] <= piece_addr;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/p2ba_ctrl.sv @@
// ----------------------------------------------------------------------------
// p2ba_ctrl
// Sequencer for the allocator: accept, bin pop, free split loop, result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module p2ba_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             request_valid,
	output logic            request_stall,
	output logic            response_valid,
	input  wire             response_stall,
	input  p2ba_pkg::stat_t stat,
	output p2ba_pkg::cmd_t  cmd
);
	import p2ba_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_FREE = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		request_stall  = (state_q != S_IDLE);
		response_valid = (state_q == S_DONE);
		cmd.accept     = (state_q == S_IDLE) && request_valid;
		cmd.pop_done   = (state_q == S_POP);
		cmd.free_step  = (state_q == S_FREE);

		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (request_valid) begin
					priority if (stat.is_free) begin
						state_nxt = S_FREE;
					end else if (stat.pop_hit) begin
						state_nxt = S_POP;
					end else begin
						state_nxt = S_DONE;
					end
				end
			end
			S_POP: begin
				state_nxt = S_DONE;
			end
			S_FREE: begin
				if (stat.rest_zero) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (!response_stall) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

@@ sv/power_of_two_bin_allocator_top.sv @@
// ----------------------------------------------------------------------------
// power_of_two_bin_allocator_top
// Sequence: heap-top alloc registers its result at accept; bin pop reads
//   the bin store at accept, then registers that word; free clears one set
//   bit of block_size per step, one bin store write per in-range piece.
// Flow: one item at a time; next taken the cycle after the result is taken.
// Reset: bin depths and heap top cleared, heap_limit all ones; bin store
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module power_of_two_bin_allocator_top #(
	parameter int BIN_DEPTH = 256,
	parameter int NUM_BINS  = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             request_valid,
	output logic            request_stall,
	input  p2ba_pkg::req_t  request,
	output logic            response_valid,
	input  wire             response_stall,
	output p2ba_pkg::rsp_t  response,
	input  wire             limit_valid,
	output logic            limit_ready,
	input  wire [31:0]      limit_data
);
	import p2ba_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign limit_ready = 1'b1;

	p2ba_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.request_valid  (request_valid),
		.request_stall  (request_stall),
		.response_valid (response_valid),
		.response_stall (response_stall),
		.stat           (stat),
		.cmd            (cmd)
	);

	p2ba_dpath #(
		.BIN_DEPTH (BIN_DEPTH),
		.NUM_BINS  (NUM_BINS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.request    (request),
		.cmd        (cmd),
		.limit_we   (limit_valid & limit_ready),
		.limit_data (limit_data),
		.stat       (stat),
		.response   (response)
	);

endmodule

`default_nettype wire
